// ===== rtl/mas_pkg.sv =====
// Shared types, constants and helpers of the media activity sleep controller.
package mas_pkg;

  localparam int ID_W       = 32;
  localparam int CMD_W      = 3;
  localparam int DELAY_W    = 24;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 24;

  // Command codes carried in the command field of a request.
  localparam logic [CMD_W-1:0] CMD_META       = 3'd0;
  localparam logic [CMD_W-1:0] CMD_PLAY       = 3'd1;
  localparam logic [CMD_W-1:0] CMD_STOP       = 3'd2;
  localparam logic [CMD_W-1:0] CMD_CALL       = 3'd3;
  localparam logic [CMD_W-1:0] CMD_BACKGROUND = 3'd4;
  localparam logic [CMD_W-1:0] CMD_TICK       = 3'd5;

  // Configuration register indexes and their reset values.
  localparam logic [CFG_IDX_W-1:0] REG_SETTLE = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_GRACE  = 1'd1;
  localparam logic [DELAY_W-1:0]   SETTLE_RESET = 24'd5000;
  localparam logic [DELAY_W-1:0]   GRACE_RESET  = 24'd2000;

  // One source table entry.
  typedef struct packed {
    logic [ID_W-1:0] key;
    logic            used;
    logic            known;
    logic            sound;
    logic            playing;
  } mas_entry_t;

  // Per-entry verdict of the match unit.
  typedef struct packed {
    logic hit;
    logic free;
    logic drop;
  } mas_match_t;

  // An entry keeps the page audible when it plays and has sound or unknown metadata.
  function automatic logic entry_loud(mas_entry_t e);
    entry_loud = e.used & e.playing & (~e.known | e.sound);
  endfunction

endpackage

// ===== rtl/mas_if.sv =====
// Request and response channel interfaces of the media activity sleep controller.
interface mas_req_if;
  logic                        valid;
  logic                        ready;
  logic [mas_pkg::CMD_W-1:0]   command;
  logic [mas_pkg::ID_W-1:0]    source_id;
  logic                        has_audio;
  logic                        call_active;
  logic                        go_background;

  modport source (output valid, command, source_id, has_audio, call_active, go_background,
                  input ready);
  modport sink   (input valid, command, source_id, has_audio, call_active, go_background,
                  output ready);
endinterface

interface mas_rsp_if;
  logic valid;
  logic ready;
  logic is_background;
  logic is_audible;
  logic is_asleep;
  logic background_changed;
  logic audible_changed;
  logic asleep_changed;
  logic play_changed;
  logic table_overflow;

  modport source (output valid, is_background, is_audible, is_asleep, background_changed,
                  audible_changed, asleep_changed, play_changed, table_overflow,
                  input ready);
  modport sink   (input valid, is_background, is_audible, is_asleep, background_changed,
                  audible_changed, asleep_changed, play_changed, table_overflow,
                  output ready);
endinterface

// ===== rtl/mas_table.sv =====
// Source table memory: one write port, one read port with registered read data.
module mas_table #(
  parameter int DEPTH = 512,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic                clk,
  input  logic                wr_en,
  input  logic [AW-1:0]       wr_addr,
  input  mas_pkg::mas_entry_t wr_data,
  input  logic [AW-1:0]       rd_addr,
  output mas_pkg::mas_entry_t rd_data
);

  mas_pkg::mas_entry_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

// ===== rtl/mas_match.sv =====
// Match unit: compares one table entry against the requested id during a table walk.
module mas_match (
  input  mas_pkg::mas_entry_t              entry,
  input  logic [mas_pkg::ID_W-1:0]         id,
  input  logic                             drop_mode,
  output mas_pkg::mas_match_t              verdict
);

  logic droppable;

  // While forgetting, known entries that do not play are released on the fly.
  assign droppable    = drop_mode & entry.used & entry.known & ~entry.playing;
  assign verdict.drop = droppable;
  assign verdict.hit  = entry.used & (entry.key == id) & ~droppable;
  assign verdict.free = ~entry.used | droppable;

endmodule

// ===== rtl/media_activity_sleep_controller.sv =====
// Top level of the media activity sleep controller: sequencer, flags and sleep timer.
//
// The block tracks media sources in a table of TABLE_DEPTH entries held in a memory with
// one read and one write port, and walks that table one entry per clock through one match
// unit. After reset a clearing pass writes every entry, and requests are refused until it
// is done. Metadata, play and stop requests walk the table: a walk that finds the id
// stops there, otherwise it covers the whole table. A metadata request that finds
// REMEMBER_LIMIT or more sources remembered forgets every idle source in the same walk
// and always covers the whole table. One request is handled at a time; the response
// sits in an output register, so a new request can be taken while the previous response
// still waits to be taken. The audible state comes from a running count of loud entries
// kept up to date on every table write, so no second walk is needed. The settle and
// grace delays are counted in tick requests.
module media_activity_sleep_controller #(
  parameter int REMEMBER_LIMIT = 256,
  parameter int TABLE_DEPTH    = 512
) (
  input  logic                                clk,
  input  logic                                rst,
  mas_req_if.sink                             req,
  mas_rsp_if.source                           rsp,
  input  logic                                cfg_wr_en,
  input  logic [mas_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [mas_pkg::CFG_DATA_W-1:0]      cfg_wdata
);

  localparam int AW = $clog2(TABLE_DEPTH);
  localparam int SW = $clog2(TABLE_DEPTH + 1);
  localparam int CW = $clog2(((TABLE_DEPTH > REMEMBER_LIMIT) ? TABLE_DEPTH
                                                             : REMEMBER_LIMIT) + 1);
  localparam int LW = $clog2(TABLE_DEPTH + 1);
  localparam logic [SW-1:0] DEPTH_C = SW'(TABLE_DEPTH);
  localparam logic [CW-1:0] LIMIT_C = CW'(REMEMBER_LIMIT);

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_SCAN,
    S_UPDATE,
    S_APPLY,
    S_REFRESH,
    S_RESPOND
  } state_t;

  // Response payload held until the sink takes it.
  typedef struct packed {
    logic is_background;
    logic is_audible;
    logic is_asleep;
    logic background_changed;
    logic audible_changed;
    logic asleep_changed;
    logic play_changed;
    logic table_overflow;
  } rsp_t;

  state_t state;

  // Configuration.
  logic [mas_pkg::DELAY_W-1:0] settle_delay;
  logic [mas_pkg::DELAY_W-1:0] sound_grace_delay;

  // Captured request and the flags as they stood when it arrived.
  logic [mas_pkg::CMD_W-1:0] cmd_q;
  logic [mas_pkg::ID_W-1:0]  id_q;
  logic                      audio_q;
  logic                      call_q;
  logic                      bg_q;
  logic                      old_bg;
  logic                      old_aud;
  logic                      old_sleep;

  // Page state.
  logic                        in_call;
  logic                        background_flag;
  logic                        audible_flag;
  logic                        asleep_flag;
  logic                        timer_running;
  logic [mas_pkg::DELAY_W-1:0] timer_remaining;
  logic [CW-1:0]               known_count;
  logic [LW-1:0]               loud_count;

  // Table walk.
  logic [SW-1:0]       scan_addr;
  logic                chk_valid;
  logic [AW-1:0]       chk_addr;
  logic                drop_mode;
  logic                hit_found;
  logic [AW-1:0]       hit_idx;
  mas_pkg::mas_entry_t hit_data;
  logic                free_found;
  logic [AW-1:0]       free_idx;
  logic                overflow_q;
  logic                play_chg_q;

  // Memory and match unit connections.
  logic                wr_en;
  logic [AW-1:0]       wr_addr;
  mas_pkg::mas_entry_t wr_data;
  logic [AW-1:0]       rd_addr;
  mas_pkg::mas_entry_t rd_data;
  mas_pkg::mas_match_t verdict;

  // Entry update at the end of a walk.
  mas_pkg::mas_entry_t old_entry;
  mas_pkg::mas_entry_t new_entry;
  mas_pkg::mas_entry_t drop_entry;
  logic [AW-1:0]       tgt_addr;
  logic                tgt_ok;
  logic                loud_now;

  rsp_t rsp_q;
  logic rsp_valid;

  mas_table #(
    .DEPTH (TABLE_DEPTH)
  ) u_table (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  mas_match u_match (
    .entry     (rd_data),
    .id        (id_q),
    .drop_mode (drop_mode),
    .verdict   (verdict)
  );

  assign req.ready = (state == S_IDLE);

  assign rsp.valid              = rsp_valid;
  assign rsp.is_background      = rsp_q.is_background;
  assign rsp.is_audible         = rsp_q.is_audible;
  assign rsp.is_asleep          = rsp_q.is_asleep;
  assign rsp.background_changed = rsp_q.background_changed;
  assign rsp.audible_changed    = rsp_q.audible_changed;
  assign rsp.asleep_changed     = rsp_q.asleep_changed;
  assign rsp.play_changed       = rsp_q.play_changed;
  assign rsp.table_overflow     = rsp_q.table_overflow;

  // The page is audible during a call or while any loud entry exists.
  assign loud_now = in_call | (loud_count != '0);

  // New contents of the entry that a metadata, play or stop request lands on. A claimed
  // free entry starts from all zero.
  always_comb begin
    old_entry = hit_found ? hit_data : '0;
    new_entry = old_entry;
    tgt_addr  = hit_found ? hit_idx : free_idx;
    tgt_ok    = hit_found | (free_found & (cmd_q != mas_pkg::CMD_STOP));
    unique case (cmd_q)
      mas_pkg::CMD_META: begin
        new_entry.key   = id_q;
        new_entry.used  = 1'b1;
        new_entry.known = 1'b1;
        new_entry.sound = audio_q;
      end
      mas_pkg::CMD_PLAY: begin
        new_entry.key     = id_q;
        new_entry.used    = 1'b1;
        new_entry.playing = 1'b1;
      end
      mas_pkg::CMD_STOP: begin
        new_entry.playing = 1'b0;
        // A source with no metadata is forgotten once it stops.
        if (!old_entry.known) begin
          new_entry.used = 1'b0;
        end
      end
      default: begin
      end
    endcase
  end

  // Memory port control: the clearing pass, releases during a forgetting walk, and the
  // final entry write.
  always_comb begin
    drop_entry       = rd_data;
    drop_entry.used  = 1'b0;
    drop_entry.known = 1'b0;
    wr_en   = 1'b0;
    wr_addr = chk_addr;
    wr_data = '0;
    rd_addr = (scan_addr < DEPTH_C) ? scan_addr[AW-1:0] : '0;
    unique case (state)
      S_CLEAR: begin
        wr_en   = 1'b1;
        wr_addr = scan_addr[AW-1:0];
      end
      S_SCAN: begin
        if (chk_valid && verdict.drop) begin
          wr_en   = 1'b1;
          wr_data = drop_entry;
        end
      end
      S_UPDATE: begin
        if (tgt_ok) begin
          wr_en   = 1'b1;
          wr_addr = tgt_addr;
          wr_data = new_entry;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      settle_delay      <= mas_pkg::SETTLE_RESET;
      sound_grace_delay <= mas_pkg::GRACE_RESET;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        mas_pkg::REG_SETTLE: settle_delay      <= cfg_wdata;
        mas_pkg::REG_GRACE:  sound_grace_delay <= cfg_wdata;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= S_CLEAR;
      scan_addr       <= '0;
      chk_valid       <= 1'b0;
      in_call         <= 1'b0;
      background_flag <= 1'b0;
      audible_flag    <= 1'b0;
      asleep_flag     <= 1'b0;
      timer_running   <= 1'b0;
      timer_remaining <= '0;
      known_count     <= '0;
      loud_count      <= '0;
      rsp_valid       <= 1'b0;
    end else begin
      // A taken response empties the output register unless a new one is loaded now.
      if (rsp.ready && state != S_RESPOND) begin
        rsp_valid <= 1'b0;
      end
      unique case (state)
        S_CLEAR: begin
          scan_addr <= scan_addr + SW'(1);
          if (scan_addr == DEPTH_C - SW'(1)) begin
            state <= S_IDLE;
          end
        end

        S_IDLE: begin
          if (req.valid) begin
            cmd_q      <= req.command;
            id_q       <= req.source_id;
            audio_q    <= req.has_audio;
            call_q     <= req.call_active;
            bg_q       <= req.go_background;
            old_bg     <= background_flag;
            old_aud    <= audible_flag;
            old_sleep  <= asleep_flag;
            scan_addr  <= '0;
            chk_valid  <= 1'b0;
            hit_found  <= 1'b0;
            free_found <= 1'b0;
            overflow_q <= 1'b0;
            play_chg_q <= 1'b0;
            drop_mode  <= (req.command == mas_pkg::CMD_META) && (known_count >= LIMIT_C);
            if (req.command == mas_pkg::CMD_META || req.command == mas_pkg::CMD_PLAY ||
                req.command == mas_pkg::CMD_STOP) begin
              state <= S_SCAN;
            end else begin
              state <= S_APPLY;
            end
          end
        end

        S_SCAN: begin
          // Issue one read per cycle; its data is judged in the following cycle.
          if (scan_addr < DEPTH_C) begin
            scan_addr <= scan_addr + SW'(1);
            chk_valid <= 1'b1;
            chk_addr  <= scan_addr[AW-1:0];
          end else begin
            chk_valid <= 1'b0;
          end
          if (chk_valid) begin
            if (verdict.drop) begin
              if (known_count != '0) begin
                known_count <= known_count - CW'(1);
              end
              if (!free_found) begin
                free_found <= 1'b1;
                free_idx   <= chk_addr;
              end
            end else if (verdict.hit) begin
              hit_found <= 1'b1;
              hit_idx   <= chk_addr;
              hit_data  <= rd_data;
              // Ids are unique, so a plain lookup can stop at the first match.
              if (!drop_mode) begin
                state <= S_UPDATE;
              end
            end else if (verdict.free && !free_found) begin
              free_found <= 1'b1;
              free_idx   <= chk_addr;
            end
          end
          if (!chk_valid && scan_addr == DEPTH_C) begin
            state <= S_UPDATE;
          end
        end

        S_UPDATE: begin
          if (tgt_ok) begin
            loud_count <= loud_count - LW'(mas_pkg::entry_loud(old_entry))
                                     + LW'(mas_pkg::entry_loud(new_entry));
            if (cmd_q == mas_pkg::CMD_META && !old_entry.known) begin
              known_count <= known_count + CW'(1);
            end
          end
          overflow_q <= ~tgt_ok & (cmd_q != mas_pkg::CMD_STOP);
          play_chg_q <= (cmd_q == mas_pkg::CMD_STOP) | ((cmd_q == mas_pkg::CMD_PLAY) & tgt_ok);
          state      <= S_REFRESH;
        end

        S_APPLY: begin
          unique case (cmd_q)
            mas_pkg::CMD_CALL: begin
              in_call <= call_q;
              state   <= S_REFRESH;
            end
            mas_pkg::CMD_BACKGROUND: begin
              if (bg_q != background_flag) begin
                background_flag <= bg_q;
                if (bg_q) begin
                  if (!audible_flag) begin
                    timer_running   <= 1'b1;
                    timer_remaining <= settle_delay;
                  end
                end else begin
                  timer_running   <= 1'b0;
                  timer_remaining <= '0;
                  asleep_flag     <= 1'b0;
                end
              end
              state <= S_RESPOND;
            end
            mas_pkg::CMD_TICK: begin
              if (timer_running) begin
                if (timer_remaining <= mas_pkg::DELAY_W'(1)) begin
                  timer_running   <= 1'b0;
                  timer_remaining <= '0;
                  if (background_flag && !audible_flag) begin
                    asleep_flag <= 1'b1;
                  end
                end else begin
                  timer_remaining <= timer_remaining - mas_pkg::DELAY_W'(1);
                end
              end
              state <= S_RESPOND;
            end
            default: begin
              state <= S_RESPOND;
            end
          endcase
        end

        S_REFRESH: begin
          // Sound starting cancels the countdown; sound stopping in the background
          // while awake starts the grace countdown.
          if (loud_now != audible_flag) begin
            audible_flag <= loud_now;
            if (loud_now) begin
              timer_running   <= 1'b0;
              timer_remaining <= '0;
            end else if (background_flag && !asleep_flag) begin
              timer_running   <= 1'b1;
              timer_remaining <= sound_grace_delay;
            end
          end
          state <= S_RESPOND;
        end

        S_RESPOND: begin
          if (!rsp_valid || rsp.ready) begin
            rsp_valid                <= 1'b1;
            rsp_q.is_background      <= background_flag;
            rsp_q.is_audible         <= audible_flag;
            rsp_q.is_asleep          <= asleep_flag;
            rsp_q.background_changed <= background_flag ^ old_bg;
            rsp_q.audible_changed    <= audible_flag ^ old_aud;
            rsp_q.asleep_changed     <= asleep_flag ^ old_sleep;
            rsp_q.play_changed       <= play_chg_q;
            rsp_q.table_overflow     <= overflow_q;
            state                    <= S_IDLE;
          end
        end

        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

// ===== rtl/mas_checker.sv =====
// Port-level checks of the media activity sleep controller and their bind.
module mas_checker (
  input logic clk,
  input logic rst,
  input logic req_valid,
  input logic req_ready,
  input logic rsp_valid,
  input logic rsp_ready,
  input logic is_background,
  input logic is_audible,
  input logic is_asleep,
  input logic background_changed,
  input logic audible_changed,
  input logic asleep_changed,
  input logic play_changed,
  input logic table_overflow
);

  logic [7:0] rsp_bits;

  assign rsp_bits = {is_background, is_audible, is_asleep, background_changed,
                     audible_changed, asleep_changed, play_changed, table_overflow};

  // No response is offered right after reset.
  a_reset_quiet: assert property (@(posedge clk) rst |=> !rsp_valid)
    else $error("response valid after reset");

  // A stalled response keeps its contents.
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_bits))
    else $error("stalled response changed");

  // A taken request keeps the block busy, so requests are never taken back to back.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready |=> !req_ready)
    else $error("request taken in back-to-back cycles");

  // Sleep is only possible in the background.
  a_sleep_in_background: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && is_asleep |-> is_background)
    else $error("asleep while in foreground");

  // A dropped request never reports a play change.
  a_overflow_no_play: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && table_overflow |-> !play_changed)
    else $error("overflow reported together with play change");

endmodule

bind media_activity_sleep_controller mas_checker u_mas_checker (
  .clk                (clk),
  .rst                (rst),
  .req_valid          (req.valid),
  .req_ready          (req.ready),
  .rsp_valid          (rsp.valid),
  .rsp_ready          (rsp.ready),
  .is_background      (rsp.is_background),
  .is_audible         (rsp.is_audible),
  .is_asleep          (rsp.is_asleep),
  .background_changed (rsp.background_changed),
  .audible_changed    (rsp.audible_changed),
  .asleep_changed     (rsp.asleep_changed),
  .play_changed       (rsp.play_changed),
  .table_overflow     (rsp.table_overflow)
);
